FILE: design/bole_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bole_pkg;

  localparam int DATA_W       = 32;
  localparam int POS_W        = 4;
  localparam int CNT_OUT_W    = 5;
  localparam int CAPACITY_DEF = 16;
  localparam int IN_TDATA_W   = 40;
  localparam int OUT_TDATA_W  = 40;

  typedef enum logic [1:0] {
    MODE_HEAD   = 2'd0,
    MODE_TAIL   = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic              fire;
    logic              do_head;
    logic              do_tail;
    mode_t             mode;
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  pos;
  } op_t;

endpackage

`default_nettype wire

FILE: design/bole_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module bole_cell
  import bole_pkg::*;
#(
  parameter int CNT_W = 5,
  parameter int IDX   = 0
) (
  input  wire logic              clk,
  input  wire op_t               op,
  input  wire logic [CNT_W-1:0]  count,
  input  wire logic [DATA_W-1:0] left_entry,
  input  wire logic [DATA_W-1:0] right_entry,
  input  wire logic              hit_in,
  input  wire logic [DATA_W-1:0] rd_in,
  output logic      [DATA_W-1:0] entry,
  output logic                   hit_out,
  output logic      [DATA_W-1:0] rd_out
);

  localparam int PW = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);
  localparam logic [PW-1:0]    IDX_P = PW'(IDX);

  logic held;
  logic match;
  logic rd_sel;

  assign held    = IDX_C < count;
  assign match   = held && (op.mode == MODE_REMOVE) && (entry == op.value);
  assign hit_out = hit_in | match;
  assign rd_sel  = held && (op.mode == MODE_READ) && (PW'(op.pos) == IDX_P);
  assign rd_out  = rd_in | (rd_sel ? entry : '0);

  always_ff @(posedge clk) begin
    priority if (op.do_head) begin
      entry <= left_entry;
    end else if (op.do_tail && (count == IDX_C)) begin
      entry <= op.value;
    end else if (op.fire && (op.mode == MODE_REMOVE) && (hit_in || match)) begin
      entry <= right_entry;
    end else begin
      entry <= entry;
    end
  end

endmodule

`default_nettype wire

FILE: design/bounded_ordered_list_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells,
// head at position 0. Every input beat (insert at head, append at tail,
// remove first equal, read position) is handled by all cells: they compare
// and shift together, and one result beat is registered on the next edge.
// A new beat is taken every cycle while the result register is free or being
// drained, so the rate is one beat per cycle, limited only by output stalls.
// Entries are not cleared at reset; only held positions are ever read.

module bounded_ordered_list_engine
  import bole_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // value[31:0], position[35:32]
  input  wire logic [1:0]             s_axis_tuser,  // mode[1:0]
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,  // entry_count[4:0], read_value[36:5]
  output logic      [1:0]             m_axis_tuser   // status[1:0]
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int PW    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic                 fire;
  logic                 full;
  logic                 read_ok;
  op_t                  op;
  status_t              status_next;
  logic [DATA_W-1:0]    rd_next;

  logic [DATA_W-1:0]    ent [CAPACITY];
  logic                 hit [CAPACITY+1];
  logic [DATA_W-1:0]    rd  [CAPACITY+1];

  logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;
  logic [CNT_OUT_W-1:0]       count_q;
  status_t                    status_q;
  logic [DATA_W-1:0]          rd_q;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign fire          = s_axis_tvalid && s_axis_tready;
  assign full          = count == CAP_C;

  assign op.fire    = fire;
  assign op.mode    = mode_t'(s_axis_tuser);
  assign op.value   = s_axis_tdata[DATA_W-1:0];
  assign op.pos     = s_axis_tdata[DATA_W+POS_W-1:DATA_W];
  assign op.do_head = fire && (op.mode == MODE_HEAD) && !full;
  assign op.do_tail = fire && (op.mode == MODE_TAIL) && !full;

  assign hit[0] = 1'b0;
  assign rd[0]  = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_entry;
    logic [DATA_W-1:0] right_entry;

    if (i == 0) begin : g_first
      assign left_entry = op.value;
    end else begin : g_mid
      assign left_entry = ent[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = ent[i];
    end else begin : g_inner
      assign right_entry = ent[i+1];
    end

    bole_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk         (clk),
      .op          (op),
      .count       (count),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .hit_in      (hit[i]),
      .rd_in       (rd[i]),
      .entry       (ent[i]),
      .hit_out     (hit[i+1]),
      .rd_out      (rd[i+1])
    );
  end

  assign read_ok = PW'(op.pos) < PW'(count);

  always_comb begin
    count_next  = count;
    status_next = ST_DONE;
    rd_next     = '0;
    unique case (op.mode)
      MODE_HEAD, MODE_TAIL: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      MODE_REMOVE: begin
        if (hit[CAPACITY]) begin
          count_next = count - CNT_W'(1);
        end else begin
          status_next = ST_MISS;
        end
      end
      MODE_READ: begin
        if (read_ok) begin
          rd_next = rd[CAPACITY];
        end else begin
          status_next = ST_MISS;
        end
      end
      default: begin
        status_next = ST_MISS;
      end
    endcase
  end

  assign cnt_ext = (CNT_W+CNT_OUT_W)'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        count         <= count_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      count_q  <= cnt_ext[CNT_OUT_W-1:0];
      status_q <= status_next;
      rd_q     <= rd_next;
    end
  end

  assign m_axis_tdata = {{(OUT_TDATA_W-DATA_W-CNT_OUT_W){1'b0}}, rd_q, count_q};
  assign m_axis_tuser = status_q;

endmodule

`default_nettype wire
